FILE: hw/rtl/pbld_pkg.sv
// Shared types and constants of the page buffer LRU directory.
package pbld_pkg;

  localparam int TABLE_W = 8;
  localparam int PAGE_W  = 32;
  localparam int FRAME_W = 4;
  localparam int COUNT_W = 5;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_CLOSE  = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_HIT,
    OP_FILL,
    OP_RELEASE
  } cell_op_e;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stack_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CLOSE,
    ST_REPLY
  } fsm_state_e;

  typedef struct packed {
    cell_op_e             op;
    logic [TABLE_W-1:0]   table_ident;
    logic [PAGE_W-1:0]    page_number;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/pbld_stack_cell.sv
// One entry of the free frame stack, shifting toward its neighbors on push and pop.
module pbld_stack_cell import pbld_pkg::*; #(
  parameter int IW = 4
) (
  input  logic          clk_i,
  input  stack_op_e     op_i,
  input  logic [IW-1:0] above_i,
  input  logic [IW-1:0] below_i,
  output logic [IW-1:0] entry_o
);

  logic [IW-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      STK_PUSH: entry_q <= above_i;
      STK_POP:  entry_q <= below_i;
      default:  entry_q <= entry_q;
    endcase
  end

  assign entry_o = entry_q;

endmodule

FILE: hw/rtl/pbld_frame_cell.sv
// One directory frame: tag, valid bit and recency rank, updated by broadcast commands.
module pbld_frame_cell import pbld_pkg::*; #(
  parameter int IW       = 4,
  parameter int CELL_IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               probe_i,
  input  logic [TABLE_W-1:0] probe_table_i,
  input  logic [PAGE_W-1:0]  probe_page_i,
  input  logic [IW-1:0]      lru_rank_i,
  input  cell_cmd_t          cmd_i,
  input  logic [IW-1:0]      sel_frame_i,
  input  logic [IW-1:0]      ref_rank_i,
  output logic               match_o,
  output logic               lru_o,
  output logic               cand_o,
  output logic [IW-1:0]      rank_o,
  output logic [TABLE_W-1:0] table_o,
  output logic [PAGE_W-1:0]  page_o
);

  logic               valid_q, valid_d;
  logic [IW-1:0]      rank_q, rank_d;
  logic [TABLE_W-1:0] table_q;
  logic [PAGE_W-1:0]  page_q;
  logic               match_q, lru_q;
  logic               self;

  assign self   = (sel_frame_i == IW'(CELL_IDX));
  // this frame is the one at the swept rank and belongs to the closing table
  assign cand_o = valid_q && (rank_q == ref_rank_i) && (table_q == cmd_i.table_ident);

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    case (cmd_i.op)
      OP_HIT: begin
        if (self) begin
          rank_d = '0;
        end else if (valid_q && (rank_q < ref_rank_i)) begin
          rank_d = rank_q + IW'(1);
        end
      end
      OP_FILL: begin
        if (self) begin
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + IW'(1);
        end
      end
      OP_RELEASE: begin
        if (cand_o) begin
          valid_d = 1'b0;
          rank_d  = '0;
        end else if (valid_q && (rank_q > ref_rank_i)) begin
          rank_d = rank_q - IW'(1);
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      match_q <= 1'b0;
      lru_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      if (probe_i) begin
        match_q <= valid_q && (table_q == probe_table_i) && (page_q == probe_page_i);
        lru_q   <= valid_q && (rank_q == lru_rank_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_FILL) && self) begin
      table_q <= cmd_i.table_ident;
      page_q  <= cmd_i.page_number;
    end
  end

  assign match_o = match_q;
  assign lru_o   = lru_q;
  assign rank_o  = rank_q;
  assign table_o = table_q;
  assign page_o  = page_q;

endmodule

FILE: hw/rtl/page_buffer_lru_directory_top.sv
// Page buffer LRU directory: a row of frame cells, a shifting free stack and a sequencer.
//
// Input channel (in_valid_i/in_ready_o) takes one word: a command, a table
// and a page number. A lookup reports hit or miss, the frame now holding the
// page, and the tag of the least recently used frame if it had to be evicted.
// A close frees every frame of the table, oldest first, and reports the count.
// Output channel (out_valid_o/out_ready_i) returns one word per input word.
// A lookup first registers the tag compare in every frame cell as it is
// accepted; then, once the output register is free, it updates ranks, tags
// and the free stack and loads the output register. A close sweeps the
// recency ranks from oldest to newest, one rank per cycle. The input is
// taken only while the sequencer is idle; a finished word waits in the
// output register, and while the receiver stalls with a word still held,
// the next result waits in its last step until the register frees up.
// Reset empties the directory: no valid frames, empty free stack, frames are
// handed out from index 0 upward.
module page_buffer_lru_directory_top import pbld_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_command_i,
  input  logic [TABLE_W-1:0] in_table_ident_i,
  input  logic [PAGE_W-1:0]  in_page_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_hit_o,
  output logic [FRAME_W-1:0] out_frame_o,
  output logic               out_evicted_o,
  output logic [TABLE_W-1:0] out_victim_table_o,
  output logic [PAGE_W-1:0]  out_victim_page_o,
  output logic [COUNT_W-1:0] out_freed_count_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  fsm_state_e         state_q, state_d;
  logic [TABLE_W-1:0] req_table_q, req_table_d;
  logic [PAGE_W-1:0]  req_page_q, req_page_d;
  logic [IW-1:0]      rank_ptr_q, rank_ptr_d;
  logic [CW-1:0]      freed_q, freed_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      depth_q, depth_d;
  logic [CW-1:0]      next_unused_q, next_unused_d;
  logic [CW-1:0]      count_m1;

  logic               out_valid_q, out_valid_d;
  logic               out_hit_q, out_hit_d;
  logic [FRAME_W-1:0] out_frame_q, out_frame_d;
  logic               out_evicted_q, out_evicted_d;
  logic [TABLE_W-1:0] out_vt_q, out_vt_d;
  logic [PAGE_W-1:0]  out_vp_q, out_vp_d;
  logic [COUNT_W-1:0] out_freed_q, out_freed_d;
  logic               out_load, out_free;

  logic               probe;
  cell_cmd_t          cmd;
  logic [IW-1:0]      sel_frame, ref_rank;
  stack_op_e          stk_op;

  logic [SLOTS-1:0]   match, lru, cand;
  logic [IW-1:0]      rank   [SLOTS];
  logic [TABLE_W-1:0] ftable [SLOTS];
  logic [PAGE_W-1:0]  fpage  [SLOTS];
  logic [IW-1:0]      stk    [SLOTS];

  logic               hit, full, any_cand;
  logic [IW-1:0]      hit_idx, hit_rank, lru_idx, cand_idx, alloc_idx;
  logic [TABLE_W-1:0] lru_table;
  logic [PAGE_W-1:0]  lru_page;
  logic [IW+FRAME_W-1:0] frame_ext;
  logic [CW+COUNT_W-1:0] freed_ext;

  assign count_m1 = count_q - CW'(1);

  // frame cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_frame
    pbld_frame_cell #(
      .IW       (IW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .probe_i       (probe),
      .probe_table_i (in_table_ident_i),
      .probe_page_i  (in_page_number_i),
      .lru_rank_i    (count_m1[IW-1:0]),
      .cmd_i         (cmd),
      .sel_frame_i   (sel_frame),
      .ref_rank_i    (ref_rank),
      .match_o       (match[g]),
      .lru_o         (lru[g]),
      .cand_o        (cand[g]),
      .rank_o        (rank[g]),
      .table_o       (ftable[g]),
      .page_o        (fpage[g])
    );
  end

  // free stack, top of stack at entry 0
  for (genvar g = 0; g < SLOTS; g++) begin : g_stack
    logic [IW-1:0] above, below;
    if (g == 0) begin : g_top
      assign above = cand_idx;
    end else begin : g_mid
      assign above = stk[g-1];
    end
    if (g == SLOTS - 1) begin : g_last
      assign below = stk[g];
    end else begin : g_inner
      assign below = stk[g+1];
    end
    pbld_stack_cell #(
      .IW (IW)
    ) u_entry (
      .clk_i   (clk_i),
      .op_i    (stk_op),
      .above_i (above),
      .below_i (below),
      .entry_o (stk[g])
    );
  end

  // one-hot selects from the cells; at most one cell raises each of them
  always_comb begin
    hit_idx   = '0;
    hit_rank  = '0;
    lru_idx   = '0;
    cand_idx  = '0;
    lru_table = '0;
    lru_page  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank[i];
      end
      if (lru[i]) begin
        lru_idx   = lru_idx | IW'(i);
        lru_table = lru_table | ftable[i];
        lru_page  = lru_page | fpage[i];
      end
      if (cand[i]) begin
        cand_idx = cand_idx | IW'(i);
      end
    end
  end

  assign hit      = |match;
  assign any_cand = |cand;
  assign full     = (count_q == CW'(SLOTS));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (full) begin
      alloc_idx = lru_idx;
    end else if (depth_q != '0) begin
      alloc_idx = stk[0];
    end else begin
      alloc_idx = next_unused_q[IW-1:0];
    end
  end

  assign frame_ext = {{FRAME_W{1'b0}}, sel_frame};
  assign freed_ext = {{COUNT_W{1'b0}}, freed_q};

  always_comb begin
    state_d         = state_q;
    req_table_d     = req_table_q;
    req_page_d      = req_page_q;
    rank_ptr_d      = rank_ptr_q;
    freed_d         = freed_q;
    count_d         = count_q;
    depth_d         = depth_q;
    next_unused_d   = next_unused_q;
    in_ready_o      = (state_q == ST_IDLE);
    probe           = in_valid_i && (state_q == ST_IDLE);
    cmd.op          = OP_NONE;
    cmd.table_ident = req_table_q;
    cmd.page_number = req_page_q;
    sel_frame       = hit ? hit_idx : alloc_idx;
    ref_rank        = rank_ptr_q;
    stk_op          = STK_HOLD;
    out_load        = 1'b0;
    out_hit_d       = 1'b0;
    out_frame_d     = '0;
    out_evicted_d   = 1'b0;
    out_vt_d        = '0;
    out_vp_d        = '0;
    out_freed_d     = '0;

    case (state_q)
      ST_IDLE: begin
        if (probe) begin
          req_table_d = in_table_ident_i;
          req_page_d  = in_page_number_i;
          freed_d     = '0;
          if (in_command_i == CMD_CLOSE) begin
            if (count_q == '0) begin
              state_d = ST_REPLY;
            end else begin
              rank_ptr_d = count_m1[IW-1:0];
              state_d    = ST_CLOSE;
            end
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        ref_rank = hit_rank;
        if (out_free) begin
          cmd.op      = hit ? OP_HIT : OP_FILL;
          out_load    = 1'b1;
          out_hit_d   = hit;
          out_frame_d = frame_ext[FRAME_W-1:0];
          if (!hit) begin
            if (full) begin
              // evicted frame is freed and reused at once: allocator unchanged
              out_evicted_d = 1'b1;
              out_vt_d      = lru_table;
              out_vp_d      = lru_page;
            end else begin
              count_d = count_q + CW'(1);
              if (depth_q != '0) begin
                stk_op  = STK_POP;
                depth_d = depth_q - CW'(1);
              end else begin
                next_unused_d = next_unused_q + CW'(1);
              end
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        // release the frame at the swept rank if it belongs to the table
        if (any_cand) begin
          cmd.op  = OP_RELEASE;
          count_d = count_q - CW'(1);
          freed_d = freed_q + CW'(1);
          if (depth_q < CW'(SLOTS)) begin
            stk_op  = STK_PUSH;
            depth_d = depth_q + CW'(1);
          end
        end
        if (rank_ptr_q == '0) begin
          state_d = ST_REPLY;
        end else begin
          rank_ptr_d = rank_ptr_q - IW'(1);
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_freed_d = freed_ext[COUNT_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rank_ptr_q    <= '0;
      freed_q       <= '0;
      count_q       <= '0;
      depth_q       <= '0;
      next_unused_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rank_ptr_q    <= rank_ptr_d;
      freed_q       <= freed_d;
      count_q       <= count_d;
      depth_q       <= depth_d;
      next_unused_q <= next_unused_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_table_q <= req_table_d;
    req_page_q  <= req_page_d;
    if (out_load) begin
      out_hit_q     <= out_hit_d;
      out_frame_q   <= out_frame_d;
      out_evicted_q <= out_evicted_d;
      out_vt_q      <= out_vt_d;
      out_vp_q      <= out_vp_d;
      out_freed_q   <= out_freed_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_hit_o          = out_hit_q;
  assign out_frame_o        = out_frame_q;
  assign out_evicted_o      = out_evicted_q;
  assign out_victim_table_o = out_vt_q;
  assign out_victim_page_o  = out_vp_q;
  assign out_freed_count_o  = out_freed_q;

endmodule

FILE: tb/page_buffer_lru_directory_top_tb.sv
// Testbench of the page buffer LRU directory: lookups and closes against a shadow directory.
module page_buffer_lru_directory_top_tb;
  import pbld_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_WORDS = 1100;
  localparam int QUIET_TAIL   = 120;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic               cmd;
    logic [TABLE_W-1:0] tbl;
    logic [PAGE_W-1:0]  page_no;
  } dir_req_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [TABLE_W-1:0] victim_table;
    logic [PAGE_W-1:0]  victim_page;
    logic [COUNT_W-1:0] freed_count;
  } dir_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_cmd = CMD_LOOKUP;
  logic [TABLE_W-1:0] in_table = '0;
  logic [PAGE_W-1:0]  in_page = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_hit;
  logic [FRAME_W-1:0] out_frame;
  logic               out_evicted;
  logic [TABLE_W-1:0] out_victim_table;
  logic [PAGE_W-1:0]  out_victim_page;
  logic [COUNT_W-1:0] out_freed_count;

  page_buffer_lru_directory_top #(.SLOTS(SLOTS)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .in_command_i       (in_cmd),
    .in_table_ident_i   (in_table),
    .in_page_number_i   (in_page),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .out_hit_o          (out_hit),
    .out_frame_o        (out_frame),
    .out_evicted_o      (out_evicted),
    .out_victim_table_o (out_victim_table),
    .out_victim_page_o  (out_victim_page),
    .out_freed_count_o  (out_freed_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Directory shadow
  logic               slot_valid [SLOTS];
  logic [TABLE_W-1:0] slot_table [SLOTS];
  logic [PAGE_W-1:0]  slot_page  [SLOTS];
  int                 slot_rank  [SLOTS];
  int                 free_stack [SLOTS];
  int                 free_depth = 0;
  int                 fresh_index = 0;

  dir_req_t   pending_q [$];
  dir_reply_t reply_q   [$];

  int total_words = 0;
  int words_sent  = 0;
  int errors      = 0;
  int n_lookups = 0, n_hits = 0, n_evicts = 0, n_closes = 0, n_freed = 0, max_freed = 0;
  int send_gap = 0;
  int recv_stall = 0;
  logic quiet;

  assign quiet = (words_sent + QUIET_TAIL >= total_words);

  function automatic void release_slot(int f);
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_rank[i] > slot_rank[f]) slot_rank[i]--;
    slot_valid[f] = 1'b0;
    slot_table[f] = '0;
    slot_page[f]  = '0;
    slot_rank[f]  = 0;
    if (free_depth < SLOTS) begin
      free_stack[free_depth] = f;
      free_depth++;
    end
  endfunction

  function automatic int take_slot();
    if (free_depth > 0) begin
      free_depth--;
      return free_stack[free_depth] % SLOTS;
    end
    if (fresh_index < SLOTS) begin
      fresh_index++;
      return fresh_index - 1;
    end
    for (int i = 0; i < SLOTS; i++)
      if (!slot_valid[i]) return i;
    return 0;
  endfunction

  // Update the shadow directory with one accepted word and queue its reply.
  function automatic void predict_directory(dir_req_t req);
    dir_reply_t r;
    int f;
    int best;
    int used;
    int freed;
    logic found;
    r = '0;
    f = 0;
    used = 0;
    freed = 0;
    if (req.cmd == CMD_CLOSE) begin
      n_closes++;
      do begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_valid[i] && slot_table[i] == req.tbl &&
              (!found || slot_rank[i] > slot_rank[best])) begin
            found = 1'b1;
            best = i;
          end
        if (found) begin
          release_slot(best);
          freed++;
        end
      end while (found);
      r.freed_count = freed[COUNT_W-1:0];
      n_freed += freed;
      if (freed > max_freed) max_freed = freed;
    end else begin
      n_lookups++;
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i]) begin
          used++;
          if (!r.hit && slot_table[i] == req.tbl && slot_page[i] == req.page_no) begin
            r.hit = 1'b1;
            f = i;
          end
        end
      if (r.hit) begin
        n_hits++;
        for (int i = 0; i < SLOTS; i++)
          if (slot_valid[i] && slot_rank[i] < slot_rank[f]) slot_rank[i]++;
        slot_rank[f] = 0;
      end else begin
        if (used >= SLOTS) begin
          // Evict the oldest frame, then reuse it right away.
          found = 1'b0;
          best = 0;
          for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && (!found || slot_rank[i] > slot_rank[best])) begin
              found = 1'b1;
              best = i;
            end
          r.evicted      = 1'b1;
          r.victim_table = slot_table[best];
          r.victim_page  = slot_page[best];
          n_evicts++;
          release_slot(best);
        end
        f = take_slot();
        for (int i = 0; i < SLOTS; i++)
          if (slot_valid[i] && i != f) slot_rank[i]++;
        slot_valid[f] = 1'b1;
        slot_table[f] = req.tbl;
        slot_page[f]  = req.page_no;
        slot_rank[f]  = 0;
      end
      r.frame = f[FRAME_W-1:0];
    end
    reply_q.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      errors++;
    end
  endfunction

  task automatic push_lookup(logic [TABLE_W-1:0] t, logic [PAGE_W-1:0] p);
    pending_q.push_back('{cmd: CMD_LOOKUP, tbl: t, page_no: p});
  endtask

  task automatic push_close(logic [TABLE_W-1:0] t, logic [PAGE_W-1:0] p);
    pending_q.push_back('{cmd: CMD_CLOSE, tbl: t, page_no: p});
  endtask

  // Input side: hold each word until taken, idle in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        predict_directory('{cmd: in_cmd, tbl: in_table, page_no: in_page});
        words_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_cmd   <= pending_q[0].cmd;
          in_table <= pending_q[0].tbl;
          in_page  <= pending_q[0].page_no;
          void'(pending_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: compare each word with the oldest prediction, stall in bursts.
  always @(posedge clk_i) begin
    dir_reply_t exp;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual hit=%0b frame=%0d",
                   $time, out_hit, out_frame);
          errors++;
        end else begin
          exp = reply_q.pop_front();
          check_field("hit", 32'(exp.hit), 32'(out_hit));
          check_field("frame", 32'(exp.frame), 32'(out_frame));
          check_field("evicted", 32'(exp.evicted), 32'(out_evicted));
          check_field("victim_table", 32'(exp.victim_table), 32'(out_victim_table));
          check_field("victim_page", exp.victim_page, out_victim_page);
          check_field("freed_count", 32'(exp.freed_count), 32'(out_freed_count));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [TABLE_W-1:0] table_pool [4];
    logic [PAGE_W-1:0]  page_pool  [32];
    logic [TABLE_W-1:0] t;
    logic [PAGE_W-1:0]  base;
    int scen;
    int t_span;
    int p_span;
    int directed;

    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_table[i] = '0;
      slot_page[i]  = '0;
      slot_rank[i]  = 0;
      free_stack[i] = 0;
    end

    // Close on an empty directory, then the tag extremes, then a hit.
    push_close(8'hFF, '1);
    push_lookup(8'h00, 32'h0000_0000);
    push_lookup(8'hFF, 32'hFFFF_FFFF);
    push_lookup(8'h00, 32'hFFFF_FFFF);
    push_lookup(8'hFF, 32'h0000_0000);
    push_lookup(8'h00, 32'h0000_0000);
    // Fill the pool, then miss once more to force an eviction.
    for (int k = 1; k <= 12; k++) push_lookup(8'h01, k);
    push_lookup(8'h02, 32'h0000_0000);
    // Free a table, reuse its last freed frame, close tables with and without frames.
    push_close(8'h01, '0);
    push_lookup(8'h03, 32'h0000_0005);
    push_lookup(8'hFF, 32'hFFFF_FFFF);
    push_close(8'h00, '0);
    push_close(8'h01, '0);
    directed = pending_q.size();

    table_pool[0] = 8'h00;
    table_pool[1] = 8'hFF;
    table_pool[2] = TABLE_W'($urandom_range(1, 254));
    table_pool[3] = TABLE_W'($urandom_range(1, 254));
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < 32; i++) page_pool[i] = $urandom;

    while (pending_q.size() < directed + RANDOM_WORDS) begin
      scen = $urandom_range(0, 19);
      if (scen < 13) begin
        // Lookups over a working set of varying size: hits, misses, evictions.
        t_span = $urandom_range(0, 3);
        p_span = $urandom_range(3, 31);
        repeat ($urandom_range(4, 24))
          push_lookup(table_pool[$urandom_range(0, t_span)],
                      page_pool[$urandom_range(0, p_span)]);
      end else if (scen < 16) begin
        push_close(table_pool[$urandom_range(0, 3)], '0);
      end else if (scen < 18) begin
        // Give one table the whole pool, then close it.
        t = table_pool[$urandom_range(0, 3)];
        base = $urandom;
        for (int k = 0; k < SLOTS; k++) push_lookup(t, base + k);
        push_close(t, '0);
      end else begin
        repeat ($urandom_range(1, 6))
          if ($urandom_range(0, 1) == 0) push_lookup(TABLE_W'($urandom_range(0, 255)), $urandom);
          else push_close(TABLE_W'($urandom_range(0, 255)), $urandom);
      end
    end
    total_words = pending_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() > 0 || in_valid || reply_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d lookups (%0d hits, %0d evictions), %0d closes freeing %0d frames",
             n_lookups, n_hits, n_evicts, n_closes, n_freed);
    $display("largest close freed %0d frames; %0d mismatches", max_freed, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
